FILE: sv/status_led_debounce_controller_macros.svh
// assertion helpers for the status LED and debounce block
`ifndef STATUS_LED_DEBOUNCE_CONTROLLER_MACROS_SVH
`define STATUS_LED_DEBOUNCE_CONTROLLER_MACROS_SVH

// clocked assertion, quiet while reset is high
`define SLDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same check, also active during reset
`define SLDC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: sv/sldc_pkg.sv
package sldc_pkg;

   localparam int SWITCH_COUNT = 6;
   localparam int HISTORY_LEN  = 4;
   localparam int PIN_W        = 6;
   localparam int CNT_W        = 16;
   localparam int ELAPSED_W    = 8;
   localparam int MODE_W       = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_PERIOD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LED_A_MODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LED_B_MODE    = 3'd4;

   localparam logic [CNT_W-1:0]  SAMPLE_PERIOD_RST = 16'd5;
   localparam logic [CNT_W-1:0]  FAST_PERIOD_RST   = 16'd250;
   localparam logic [CNT_W-1:0]  SLOW_PERIOD_RST   = 16'd2000;
   localparam logic [MODE_W-1:0] MODE_AUTO         = 8'hff;
   localparam logic [MODE_W-1:0] MODE_OFF          = 8'h00;
   localparam logic [CNT_W-1:0]  CNT_MAX           = 16'hffff;

   typedef logic [HISTORY_LEN-1:0] hist_type;

   // all ones sets, all zeros clears, mixed holds
   function automatic logic qualify(input hist_type hist, input logic cur);
      logic res;
      if (hist == '1) begin
         res = 1'b1;
      end else if (hist == '0) begin
         res = 1'b0;
      end else begin
         res = cur;
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [ELAPSED_W-1:0] d);
      logic [CNT_W:0] s;
      s = {1'b0, c} + {{(CNT_W+1-ELAPSED_W){1'b0}}, d};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

endpackage

FILE: sv/status_led_debounce_controller.sv
// Status LED and switch debounce controller. Each request is one tick: the
// milliseconds since the previous tick plus the raw switch, wifi and remote
// levels. Every sample_period ms the raw levels are shifted into 4-sample
// histories; four equal samples set or clear a qualified signal, mixed
// samples hold it, and the LED drive is snapshotted. The fast and slow blink
// timers then update LED A (from the wifi state) and LED B (from the remote
// flags): fast blink while not ready, slow blink while ready but not linked,
// steady on when linked, or forced by led_x_mode (0xff auto, 0 off, else on).
// Timing: one request per cycle sustained while rsp_stall is low; a request
// is held in an input register and does all of its work in one pass into
// the response register, which drives its response. The input register
// keeps taking requests while a response waits, so req_stall only rises
// when both registers are full and rsp_stall is high.
// Configuration is written through csr_*, which is always ready; write it
// only while the block is idle.
`include "status_led_debounce_controller_macros.svh"

module status_led_debounce_controller (
   input  logic                            clock,
   input  logic                            reset,
   // tick requests
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sldc_pkg::ELAPSED_W-1:0]  req_elapsed_ms,
   input  logic [sldc_pkg::PIN_W-1:0]      req_switch_pins,
   input  logic                            req_module_ready_pin,
   input  logic                            req_module_link_pin,
   input  logic                            req_remote_ready,
   input  logic                            req_remote_link,
   // responses
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sldc_pkg::SWITCH_COUNT-1:0] rsp_switch_value,
   output logic                            rsp_module_ready,
   output logic                            rsp_module_link,
   output logic                            rsp_led_a,
   output logic                            rsp_led_b,
   output logic [1:0]                      rsp_led_snapshot,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sldc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sldc_pkg::CSR_DATA_W-1:0] csr_data
);

   import sldc_pkg::*;

   // configuration registers
   logic [CNT_W-1:0]  sample_period_ff, fast_period_ff, slow_period_ff;
   logic [MODE_W-1:0] led_a_mode_ff, led_b_mode_ff;

   // input register
   logic                 in_valid_ff;
   logic [ELAPSED_W-1:0] in_elapsed_ff;
   logic [PIN_W-1:0]     in_pins_ff;
   logic                 in_rdy_pin_ff, in_lnk_pin_ff, in_rem_rdy_ff, in_rem_lnk_ff;

   // block state
   hist_type                sw_hist_ff [SWITCH_COUNT];
   hist_type                sw_hist_in [SWITCH_COUNT];
   hist_type                rdy_hist_ff, rdy_hist_in;
   hist_type                lnk_hist_ff, lnk_hist_in;
   logic [SWITCH_COUNT-1:0] sw_state_ff, sw_state_in;
   logic                    rdy_state_ff, rdy_state_in;
   logic                    lnk_state_ff, lnk_state_in;
   logic                    rem_rdy_ff, rem_rdy_in;
   logic                    rem_lnk_ff, rem_lnk_in;
   logic [1:0]              led_ff, led_in;
   logic [1:0]              capture_ff, capture_in;
   logic [CNT_W-1:0]        cnt_sample_ff, cnt_sample_in;
   logic [CNT_W-1:0]        cnt_fast_ff, cnt_fast_in;
   logic [CNT_W-1:0]        cnt_slow_ff, cnt_slow_in;

   // response register
   logic                    rsp_valid_ff;
   logic [SWITCH_COUNT-1:0] rsp_switch_ff;
   logic                    rsp_rdy_ff, rsp_lnk_ff, rsp_led_a_ff, rsp_led_b_ff;
   logic [1:0]              rsp_capture_ff;

   logic advance;
   logic sample_hit, fast_hit, slow_hit;
   logic a_auto, b_auto;
   logic led_a_fast, led_b_fast;
   logic [SWITCH_COUNT+PIN_W-1:0] pins_ext;

   // input item moves on when the response register is free or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   assign sample_hit = cnt_sample_ff >= sample_period_ff;
   assign fast_hit   = cnt_fast_ff >= fast_period_ff;
   assign slow_hit   = cnt_slow_ff >= slow_period_ff;
   assign a_auto     = led_a_mode_ff == MODE_AUTO;
   assign b_auto     = led_b_mode_ff == MODE_AUTO;

   // switches past the pin field read as zero
   assign pins_ext = {{SWITCH_COUNT{1'b0}}, in_pins_ff};

   // sampling, debounce and snapshot
   always_comb begin
      for (int i = 0; i < SWITCH_COUNT; i++) begin
         sw_hist_in[i] = sample_hit ?
                         {sw_hist_ff[i][HISTORY_LEN-2:0], pins_ext[i]} : sw_hist_ff[i];
         sw_state_in[SWITCH_COUNT-1-i] = sample_hit ?
                         qualify(sw_hist_in[i], sw_state_ff[SWITCH_COUNT-1-i]) :
                         sw_state_ff[SWITCH_COUNT-1-i];
      end
      rdy_hist_in  = sample_hit ? {rdy_hist_ff[HISTORY_LEN-2:0], in_rdy_pin_ff} : rdy_hist_ff;
      lnk_hist_in  = sample_hit ? {lnk_hist_ff[HISTORY_LEN-2:0], in_lnk_pin_ff} : lnk_hist_ff;
      rdy_state_in = sample_hit ? qualify(rdy_hist_in, rdy_state_ff) : rdy_state_ff;
      lnk_state_in = sample_hit ? qualify(lnk_hist_in, lnk_state_ff) : lnk_state_ff;
      capture_in   = sample_hit ? led_ff : capture_ff;
   end

   // blink events: fast first, then slow, both see the new qualified state
   always_comb begin
      rem_rdy_in = (fast_hit || slow_hit) ? in_rem_rdy_ff : rem_rdy_ff;
      rem_lnk_in = (fast_hit || slow_hit) ? in_rem_lnk_ff : rem_lnk_ff;

      led_a_fast = led_ff[0];
      led_b_fast = led_ff[1];
      if (fast_hit) begin
         led_a_fast = a_auto ? (led_ff[0] ^ !rdy_state_in) : (led_a_mode_ff != MODE_OFF);
         led_b_fast = b_auto ? (led_ff[1] ^ !rem_rdy_in) : (led_b_mode_ff != MODE_OFF);
      end

      led_in = {led_b_fast, led_a_fast};
      if (slow_hit) begin
         if (rdy_state_in && a_auto) begin
            led_in[0] = lnk_state_in ? 1'b1 : !led_a_fast;
         end
         if (rem_rdy_in && b_auto) begin
            led_in[1] = rem_lnk_in ? 1'b1 : !led_b_fast;
         end
      end
   end

   // counters restart on their event, then add the elapsed time
   assign cnt_sample_in = sat_add(sample_hit ? '0 : cnt_sample_ff, in_elapsed_ff);
   assign cnt_fast_in   = sat_add(fast_hit ? '0 : cnt_fast_ff, in_elapsed_ff);
   assign cnt_slow_in   = sat_add(slow_hit ? '0 : cnt_slow_ff, in_elapsed_ff);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= SAMPLE_PERIOD_RST;
         fast_period_ff   <= FAST_PERIOD_RST;
         slow_period_ff   <= SLOW_PERIOD_RST;
         led_a_mode_ff    <= MODE_AUTO;
         led_b_mode_ff    <= MODE_AUTO;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SAMPLE_PERIOD: sample_period_ff <= csr_data;
            REG_FAST_PERIOD:   fast_period_ff   <= csr_data;
            REG_SLOW_PERIOD:   slow_period_ff   <= csr_data;
            REG_LED_A_MODE:    led_a_mode_ff    <= csr_data[MODE_W-1:0];
            REG_LED_B_MODE:    led_b_mode_ff    <= csr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_elapsed_ff <= req_elapsed_ms;
         in_pins_ff    <= req_switch_pins;
         in_rdy_pin_ff <= req_module_ready_pin;
         in_lnk_pin_ff <= req_module_link_pin;
         in_rem_rdy_ff <= req_remote_ready;
         in_rem_lnk_ff <= req_remote_link;
      end
   end

   // state update, once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SWITCH_COUNT; i++) begin
            sw_hist_ff[i] <= '0;
         end
         rdy_hist_ff   <= '0;
         lnk_hist_ff   <= '0;
         sw_state_ff   <= '0;
         rdy_state_ff  <= 1'b0;
         lnk_state_ff  <= 1'b0;
         rem_rdy_ff    <= 1'b0;
         rem_lnk_ff    <= 1'b0;
         led_ff        <= '0;
         capture_ff    <= '0;
         cnt_sample_ff <= '0;
         cnt_fast_ff   <= '0;
         cnt_slow_ff   <= '0;
      end else if (advance) begin
         for (int i = 0; i < SWITCH_COUNT; i++) begin
            sw_hist_ff[i] <= sw_hist_in[i];
         end
         rdy_hist_ff   <= rdy_hist_in;
         lnk_hist_ff   <= lnk_hist_in;
         sw_state_ff   <= sw_state_in;
         rdy_state_ff  <= rdy_state_in;
         lnk_state_ff  <= lnk_state_in;
         rem_rdy_ff    <= rem_rdy_in;
         rem_lnk_ff    <= rem_lnk_in;
         led_ff        <= led_in;
         capture_ff    <= capture_in;
         cnt_sample_ff <= cnt_sample_in;
         cnt_fast_ff   <= cnt_fast_in;
         cnt_slow_ff   <= cnt_slow_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_switch_ff  <= sw_state_in;
         rsp_rdy_ff     <= rdy_state_in;
         rsp_lnk_ff     <= lnk_state_in;
         rsp_led_a_ff   <= led_in[0];
         rsp_led_b_ff   <= led_in[1];
         rsp_capture_ff <= capture_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_switch_value = rsp_switch_ff;
   assign rsp_module_ready = rsp_rdy_ff;
   assign rsp_module_link  = rsp_lnk_ff;
   assign rsp_led_a        = rsp_led_a_ff;
   assign rsp_led_b        = rsp_led_b_ff;
   assign rsp_led_snapshot = rsp_capture_ff;

   // stall only when both registers hold a request
   `SLDC_ASSERT_ALWAYS(a_stall_full, req_stall |-> (in_valid_ff && rsp_valid_ff), "stall not full")
   // a held request is never dropped
   `SLDC_ASSERT(a_in_kept, (in_valid_ff && !advance) |=> in_valid_ff, "held request lost")
   // sample counter restarts from the tick's elapsed time
   `SLDC_ASSERT(a_sample_restart, (advance && sample_hit) |=> (cnt_sample_ff == CNT_W'($past(in_elapsed_ff))), "no restart")
   // forced-off LED A goes dark on a fast event
   `SLDC_ASSERT(a_led_a_off, (advance && fast_hit && (led_a_mode_ff == MODE_OFF)) |=> !led_ff[0], "LED lit")

endmodule
